// ----- rtl/cbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbc_pkg
// Types and constants shared by the cartridge bank controller, its channel
// interfaces and its checker.
// ----------------------------------------------------------------------------
package cbc_pkg;

   localparam logic [7:0] MAX_ROM_BANKS = 8'd128;
   localparam logic [7:0] ROM_BANK_COUNT_RESET = 8'd2;
   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

   typedef enum logic [2:0] {
      KIND_NONE        = 3'd0,
      KIND_ROM_READ    = 3'd1,
      KIND_RAM_READ    = 3'd2,
      KIND_RAM_WRITE   = 3'd3,
      KIND_RAM_BLOCKED = 3'd4,
      KIND_REG_WRITE   = 3'd5
   } kind_type;

   typedef enum logic {
      ACTION_READ  = 1'b0,
      ACTION_WRITE = 1'b1
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [15:0] bus_address;
      logic [7:0]  write_byte;
   } req_type;

   typedef struct packed {
      logic        handled;
      kind_type    access_kind;
      logic [20:0] mem_address;
      logic        fault;
   } rsp_type;

endpackage
`default_nettype wire

// ----- rtl/cbc_channels.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbc channel interfaces
// Valid/ready channels for bus requests, results and the bank-count register.
// ----------------------------------------------------------------------------
interface cbc_req_if
   import cbc_pkg::*;
();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface cbc_rsp_if
   import cbc_pkg::*;
();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface cbc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/cartridge_bank_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_bank_controller
// Bank controller for a banked cartridge: decodes CPU bus transactions into
// physical ROM/RAM addresses and updates the bank registers on writes.
// ----------------------------------------------------------------------------
// A bus transaction is taken every cycle unless an unaccepted result is held,
// and its result appears in the result register in the next cycle. Decode,
// bank update and address mapping sit in a single level of logic ahead of
// that register, so throughput is one transaction per clock. The user must
// write the ROM bank count register through the csr channel only while no
// transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module cartridge_bank_controller
   import cbc_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   cbc_req_if.sink      req_bus,
   cbc_rsp_if.source    rsp_bus,
   cbc_csr_if.sink      csr_bus
);

   logic       ram_enable_ff, ram_enable_in;
   logic [4:0] bank_low_ff, bank_low_in;
   logic [1:0] bank_high_ff, bank_high_in;
   logic [1:0] ram_bank_ff, ram_bank_in;
   logic       ram_mode_ff, ram_mode_in;
   logic [7:0] bank_count_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic        accept;
   logic [15:0] addr;
   logic [7:0]  wbyte;
   logic [6:0]  cur_bank;
   logic [6:0]  low_bank;
   logic [6:0]  high_bank;
   logic [7:0]  bank_limit;
   logic        low_fault;
   logic        high_fault;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   assign addr  = req_bus.data.bus_address;
   assign wbyte = req_bus.data.write_byte;

   assign cur_bank   = ({bank_high_ff, bank_low_ff} == 7'd0) ? 7'd1
                                                             : {bank_high_ff, bank_low_ff};
   assign low_bank   = ({bank_high_ff, wbyte[4:0]} == 7'd0) ? 7'd1
                                                            : {bank_high_ff, wbyte[4:0]};
   assign high_bank  = ({wbyte[1:0], bank_low_ff} == 7'd0) ? 7'd1
                                                           : {wbyte[1:0], bank_low_ff};
   assign bank_limit = (bank_count_ff > MAX_ROM_BANKS) ? MAX_ROM_BANKS : bank_count_ff;
   assign low_fault  = ({1'b0, low_bank} >= bank_limit);
   assign high_fault = ({1'b0, high_bank} >= bank_limit);

   always_comb begin
      ram_enable_in = ram_enable_ff;
      bank_low_in   = bank_low_ff;
      bank_high_in  = bank_high_ff;
      ram_bank_in   = ram_bank_ff;
      ram_mode_in   = ram_mode_ff;
      rsp_data_in   = '{handled: 1'b1, access_kind: KIND_NONE,
                        mem_address: 21'd0, fault: 1'b0};

      if (addr[15:13] == 3'b101) begin
         if (ram_enable_ff) begin
            rsp_data_in.access_kind = (req_bus.data.action == ACTION_WRITE) ? KIND_RAM_WRITE
                                                                          : KIND_RAM_READ;
            rsp_data_in.mem_address = {6'd0, ram_bank_ff, addr[12:0]};
         end else begin
            rsp_data_in.access_kind = KIND_RAM_BLOCKED;
         end
      end else if (addr[15]) begin
         rsp_data_in.handled = 1'b0;
      end else if (req_bus.data.action == ACTION_READ) begin
         rsp_data_in.access_kind = KIND_ROM_READ;
         if (!addr[14]) begin
            rsp_data_in.mem_address = {5'd0, addr};
         end else begin
            rsp_data_in.mem_address = {cur_bank, addr[13:0]};
         end
      end else begin
         rsp_data_in.access_kind = KIND_REG_WRITE;
         case (addr[14:13])
            2'd0: begin
               ram_enable_in = (wbyte[3:0] == RAM_ENABLE_KEY);
            end
            2'd1: begin
               bank_low_in       = wbyte[4:0];
               rsp_data_in.fault = low_fault;
            end
            2'd2: begin
               if (ram_mode_ff) begin
                  ram_bank_in       = wbyte[1:0];
                  rsp_data_in.fault = (wbyte[7:2] != 6'd0);
               end else begin
                  bank_high_in      = wbyte[1:0];
                  rsp_data_in.fault = high_fault;
               end
            end
            default: begin
               ram_mode_in       = wbyte[0];
               rsp_data_in.fault = (wbyte[7:1] != 7'd0);
            end
         endcase
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_enable_ff <= 1'b0;
         bank_low_ff   <= 5'd0;
         bank_high_ff  <= 2'd0;
         ram_bank_ff   <= 2'd0;
         ram_mode_ff   <= 1'b0;
         bank_count_ff <= ROM_BANK_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            ram_enable_ff <= ram_enable_in;
            bank_low_ff   <= bank_low_in;
            bank_high_ff  <= bank_high_in;
            ram_bank_ff   <= ram_bank_in;
            ram_mode_ff   <= ram_mode_in;
         end
         if (csr_bus.valid) begin
            bank_count_ff <= csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/cbc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbc_checker
// Port-level checks on the cartridge bank controller, bound into that module.
// ----------------------------------------------------------------------------
module cbc_checker
   import cbc_pkg::*;
(
   input wire          clock,
   input wire          reset,
   input wire          req_valid,
   input wire          req_ready,
   input wire          rsp_valid,
   input wire          rsp_ready,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result transaction dropped or changed while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_unhandled_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.handled |->
         rsp_data.access_kind == KIND_NONE && rsp_data.mem_address == 21'd0
         && !rsp_data.fault)
      else $error("unhandled transaction carries a kind, address or fault");

   a_fault_on_reg_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.fault || rsp_data.access_kind == KIND_RAM_BLOCKED
                    || rsp_data.access_kind == KIND_REG_WRITE) |->
         rsp_data.mem_address == 21'd0
         && (!rsp_data.fault || rsp_data.access_kind == KIND_REG_WRITE))
      else $error("address or fault on the wrong kind of transaction");

   a_accept_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with no result pending");

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  (rsp_bus.data)
);
`default_nettype wire

// ----- bench/tb_cartridge_bank_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartridge_bank_controller
// Drives CPU bus transactions into the cartridge bank controller under
// several ROM bank counts. A bank-mapping tracker predicts each result and
// checks it against what the block returns. Both sides of the channels idle
// at random.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_controller;
   import cbc_pkg::*;

   localparam logic [15:0] ROM_SWITCH_LO = 16'h4000;
   localparam logic [15:0] ROM_HI        = 16'h7FFF;
   localparam logic [15:0] BANK_LO_SEL   = 16'h2000;
   localparam logic [15:0] BANK_HI_SEL   = 16'h4000;
   localparam logic [15:0] MODE_SEL      = 16'h6000;
   localparam logic [15:0] RAM_LO        = 16'hA000;
   localparam logic [15:0] RAM_HI        = 16'hBFFF;
   localparam int unsigned ROM_BANK_SIZE = 'h4000;
   localparam int unsigned RAM_BANK_SIZE = 'h2000;
   localparam int          PHASES        = 8;
   localparam int          PHASE_ITEMS   = 119;
   localparam int          LONG_HOLD     = 120;

   class bank_map_checker;
      logic [7:0]  bank_count;
      logic        ram_enable;
      logic [4:0]  rom_low;
      logic [1:0]  rom_high;
      logic [1:0]  ram_bank;
      logic        ram_mode;
      rsp_type     expected_access[$];
      int unsigned mismatches;

      function new();
         bank_count = ROM_BANK_COUNT_RESET;
         ram_enable = 1'b0;
         rom_low    = '0;
         rom_high   = '0;
         ram_bank   = '0;
         ram_mode   = 1'b0;
         mismatches = 0;
      endfunction

      function int unsigned rom_bank();
         int unsigned b;
         b = {rom_high, rom_low};
         return (b == 0) ? 1 : b;
      endfunction

      function logic rom_fault();
         int unsigned lim;
         lim = (bank_count > MAX_ROM_BANKS) ? MAX_ROM_BANKS : bank_count;
         return rom_bank() >= lim;
      endfunction

      function rsp_type map_access(req_type r);
         rsp_type     e;
         logic [15:0] a;
         a = r.bus_address;
         e.handled     = 1'b1;
         e.access_kind = KIND_NONE;
         e.mem_address = '0;
         e.fault       = 1'b0;
         if (a >= RAM_LO && a <= RAM_HI) begin
            if (ram_enable) begin
               e.access_kind = (r.action == ACTION_WRITE) ? KIND_RAM_WRITE : KIND_RAM_READ;
               e.mem_address = 21'(ram_bank * RAM_BANK_SIZE + (a - RAM_LO));
            end else begin
               e.access_kind = KIND_RAM_BLOCKED;
            end
         end else if (a > ROM_HI) begin
            e.handled = 1'b0;
         end else if (r.action == ACTION_READ) begin
            e.access_kind = KIND_ROM_READ;
            if (a < ROM_SWITCH_LO) begin
               e.mem_address = 21'(a);
            end else begin
               e.mem_address = 21'(rom_bank() * ROM_BANK_SIZE + (a - ROM_SWITCH_LO));
            end
         end else begin
            e.access_kind = KIND_REG_WRITE;
            if (a < BANK_LO_SEL) begin
               ram_enable = (r.write_byte[3:0] == RAM_ENABLE_KEY);
            end else if (a < BANK_HI_SEL) begin
               rom_low = r.write_byte[4:0];
               e.fault = rom_fault();
            end else if (a < MODE_SEL) begin
               if (ram_mode) begin
                  e.fault  = (r.write_byte > 8'd3);
                  ram_bank = r.write_byte[1:0];
               end else begin
                  rom_high = r.write_byte[1:0];
                  e.fault  = rom_fault();
               end
            end else begin
               e.fault  = (r.write_byte > 8'd1);
               ram_mode = r.write_byte[0];
            end
         end
         return e;
      endfunction

      function void note_access(req_type r);
         expected_access.push_back(map_access(r));
      endfunction

      function void check_access(rsp_type got);
         rsp_type want;
         if (expected_access.size() == 0) begin
            $error("result with no transaction outstanding: %h", got);
            mismatches++;
            return;
         end
         want = expected_access.pop_front();
         if (got.handled !== want.handled) begin
            $error("handled: expected %0d, got %0d", want.handled, got.handled);
            mismatches++;
         end
         if (got.access_kind !== want.access_kind) begin
            $error("access_kind: expected %0d, got %0d", want.access_kind, got.access_kind);
            mismatches++;
         end
         if (got.mem_address !== want.mem_address) begin
            $error("mem_address: expected %h, got %h", want.mem_address, got.mem_address);
            mismatches++;
         end
         if (got.fault !== want.fault) begin
            $error("fault: expected %0d, got %0d", want.fault, got.fault);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_access.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   long_hold = 1'b0;
   int   send_run = 0;
   bit   send_quiet = 1'b0;
   int   take_run = 0;
   bit   take_quiet = 1'b0;

   bank_map_checker tracker = new();

   cbc_req_if req_ch ();
   cbc_rsp_if rsp_ch ();
   cbc_csr_if csr_ch ();

   cartridge_bank_controller i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch.sink),
      .rsp_bus (rsp_ch.source),
      .csr_bus (csr_ch.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) tracker.note_access(req_ch.data);
         if (rsp_ch.valid && rsp_ch.ready) tracker.check_access(rsp_ch.data);
      end
   end

   function automatic int draw_wait(inout int run_left, inout bit quiet);
      if (run_left == 0) begin
         run_left = $urandom_range(8, 40);
         quiet    = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      return quiet ? 0 : $urandom_range(0, 11);
   endfunction

   function automatic req_type random_access();
      req_type r;
      int      pick;
      pick         = $urandom_range(0, 99);
      r.action     = action_type'($urandom_range(0, 1));
      r.write_byte = 8'($urandom);
      if (pick < 25) begin
         r.action      = ACTION_READ;
         r.bus_address = 16'($urandom_range(0, ROM_HI));
      end else if (pick < 45) begin
         r.bus_address = 16'($urandom_range(RAM_LO, RAM_HI));
      end else if (pick < 75) begin
         r.action      = ACTION_WRITE;
         r.bus_address = 16'($urandom_range(0, ROM_HI));
         if ($urandom_range(0, 1) == 0) r.write_byte = 8'($urandom_range(0, 3));
         if (r.bus_address < BANK_LO_SEL && $urandom_range(0, 1) == 0)
            r.write_byte[3:0] = RAM_ENABLE_KEY;
      end else if (pick < 85) begin
         r.bus_address = ($urandom_range(0, 1) == 0) ? 16'($urandom_range('h8000, 'h9FFF))
                                                     : 16'($urandom_range('hC000, 'hFFFF));
      end else begin
         r.bus_address = 16'($urandom);
      end
      return r;
   endfunction

   task automatic send_access(input req_type r);
      int gap;
      gap = draw_wait(send_run, send_quiet);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic bus(input action_type act, input logic [15:0] addr, input logic [7:0] b);
      req_type r;
      r.action      = act;
      r.bus_address = addr;
      r.write_byte  = b;
      send_access(r);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (tracker.pending() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_bank_count(input logic [7:0] count);
      wait_idle();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= count;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      tracker.bank_count = count;
   endtask

   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold = 1'b0;
         end
         stall = draw_wait(take_run, take_quiet);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      logic [7:0] counts[PHASES];
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.data  <= '0;
      counts = '{8'd128, 8'd2, 8'd0, 8'd255, 8'($urandom_range(2, 128)),
                 8'($urandom), 8'd64, 8'd127};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fixed and switchable ROM, disabled RAM, unmapped space
      bus(ACTION_READ,  16'h0000, 8'h00);
      bus(ACTION_READ,  16'h3FFF, 8'hFF);
      bus(ACTION_READ,  16'h4000, 8'h00);
      bus(ACTION_READ,  16'h7FFF, 8'h00);
      bus(ACTION_READ,  16'hA000, 8'h00);
      bus(ACTION_WRITE, 16'hBFFF, 8'h55);
      bus(ACTION_READ,  16'h8000, 8'h00);
      bus(ACTION_WRITE, 16'hFFFF, 8'hFF);
      // enable RAM, walk bank registers to their limits
      bus(ACTION_WRITE, 16'h0000, 8'h0A);
      bus(ACTION_WRITE, 16'h1FFF, 8'hFA);
      bus(ACTION_READ,  16'hA000, 8'h00);
      bus(ACTION_WRITE, 16'hBFFF, 8'hFF);
      bus(ACTION_WRITE, 16'h2000, 8'h00);
      bus(ACTION_WRITE, 16'h3FFF, 8'hFF);
      bus(ACTION_WRITE, 16'h4000, 8'h03);
      bus(ACTION_READ,  16'h7FFF, 8'h00);
      bus(ACTION_WRITE, 16'h5FFF, 8'hFF);
      // RAM banking mode and mode faults
      bus(ACTION_WRITE, 16'h7FFF, 8'hFE);
      bus(ACTION_WRITE, 16'h6000, 8'h01);
      bus(ACTION_WRITE, 16'h5FFF, 8'h03);
      bus(ACTION_READ,  16'hBFFF, 8'h00);
      bus(ACTION_WRITE, 16'h4000, 8'h04);
      bus(ACTION_WRITE, 16'h1000, 8'h00);
      bus(ACTION_READ,  16'hA123, 8'h00);
      bus(ACTION_WRITE, 16'h6000, 8'h00);

      for (int p = 0; p < PHASES; p++) begin
         write_bank_count(counts[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 0 && i == 30) long_hold = 1'b1;
            if (p == 2 && i == 60) wait_idle();
            send_access(random_access());
         end
      end

      wait_idle();
      repeat (5) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/cbc_pkg.sv
rtl/cbc_channels.sv
rtl/cartridge_bank_controller.sv
rtl/cbc_checker.sv
bench/tb_cartridge_bank_controller.sv
